@@ rtl/bor_pkg.sv @@
package bor_pkg;

   // Fixed widths of the channel fields
   localparam int SET_IDX_BITS  = 6;
   localparam int TAG_IN_BITS   = 32;
   localparam int NEXT_USE_IN_BITS = 32;
   localparam int TILE_BITS     = 16;
   localparam int WAY_OUT_BITS  = 3;

   // Request command codes
   localparam logic CMD_ACCESS = 1'b0;
   localparam logic CMD_FLUSH  = 1'b1;

   // Controller to datapath commands
   typedef struct packed {
      logic clear_step;   // write one cleared row during the clearing pass
      logic capture;      // register the request and read the set rows
      logic resolve;      // decide, write back the set and load the result
   } ctl_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic clear_last;   // clearing pass is at its last row
      logic rsp_free;     // result register is empty or being drained
   } ctl_stat_type;

endpackage

@@ rtl/bor_req_if.sv @@
interface bor_req_if;
   logic                                   valid;
   logic                                   ready;
   logic                                   cmd;
   logic [bor_pkg::SET_IDX_BITS-1:0]       set_index;
   logic [bor_pkg::TAG_IN_BITS-1:0]        tag;
   logic [bor_pkg::NEXT_USE_IN_BITS-1:0]   reuse_pos;
   logic [bor_pkg::TILE_BITS-1:0]          tile;

   modport source (output valid, cmd, set_index, tag, reuse_pos, tile, input ready);
   modport sink   (input valid, cmd, set_index, tag, reuse_pos, tile, output ready);
endinterface

@@ rtl/bor_rsp_if.sv @@
interface bor_rsp_if;
   logic                                valid;
   logic                                ready;
   logic                                hit;
   logic [bor_pkg::WAY_OUT_BITS-1:0]    way_used;
   logic                                evicted_valid;
   logic [bor_pkg::TILE_BITS-1:0]       hit_tile;

   modport source (output valid, hit, way_used, evicted_valid, hit_tile, input ready);
   modport sink   (input valid, hit, way_used, evicted_valid, hit_tile, output ready);
endinterface

@@ rtl/bor_ram.sv @@
module bor_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                                 clock,
   input  logic                                 wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                     wr_data,
   input  logic                                 rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one row, read one row into the output register
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/bor_ctrl.sv @@
module bor_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  bor_pkg::ctl_stat_type stat,
   output bor_pkg::ctl_cmd_type  cmd
);

   typedef enum logic [2:0] {
      ST_CLEAR = 3'b001,
      ST_IDLE  = 3'b010,
      ST_LOOK  = 3'b100
   } state_type;

   state_type state_ff;
   state_type state_in;

   // Sequence: clearing pass, then accept one request, then resolve it
   always_comb begin
      state_in       = state_ff;
      req_ready      = 1'b0;
      cmd.clear_step = 1'b0;
      cmd.capture    = 1'b0;
      cmd.resolve    = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (stat.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_LOOK;
            end
         end
         ST_LOOK: begin
            // hold the row until the result register can take the answer
            if (stat.rsp_free) begin
               cmd.resolve = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ rtl/bor_datapath.sv @@
module bor_datapath #(
   parameter int SET_COUNT     = 64,
   parameter int NUM_WAYS      = 8,
   parameter int TAG_BITS      = 32,
   parameter int NEXT_USE_BITS = 32
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  bor_pkg::ctl_cmd_type                     cmd,
   output bor_pkg::ctl_stat_type                    stat,
   input  logic                                     req_cmd,
   input  logic [bor_pkg::SET_IDX_BITS-1:0]         req_set_index,
   input  logic [bor_pkg::TAG_IN_BITS-1:0]          req_tag,
   input  logic [bor_pkg::NEXT_USE_IN_BITS-1:0]     req_reuse_pos,
   input  logic [bor_pkg::TILE_BITS-1:0]            req_tile,
   output logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   output logic                                     rsp_hit,
   output logic [bor_pkg::WAY_OUT_BITS-1:0]         rsp_way_used,
   output logic                                     rsp_evicted_valid,
   output logic [bor_pkg::TILE_BITS-1:0]            rsp_hit_tile
);

   localparam int SET_BITS  = SET_COUNT > 1 ? $clog2(SET_COUNT) : 1;
   localparam int WAY_BITS  = NUM_WAYS > 1 ? $clog2(NUM_WAYS) : 1;
   localparam int LEVELS    = NUM_WAYS > 1 ? $clog2(NUM_WAYS) : 0;
   localparam int PAD_WAYS  = 1 << LEVELS;
   localparam int TL_BITS   = bor_pkg::TILE_BITS;
   localparam int ST_WIDTH  = NUM_WAYS * (1 + NEXT_USE_BITS);
   localparam int TAG_WIDTH = NUM_WAYS * TAG_BITS;
   localparam int TL_WIDTH  = NUM_WAYS * TL_BITS;
   // valid bits low, next-use fields above; cleared row means no future use
   localparam logic [ST_WIDTH-1:0] CLEAR_ROW = {{(NUM_WAYS * NEXT_USE_BITS){1'b1}},
                                                {NUM_WAYS{1'b0}}};

   // Registered request
   logic                     cmd_ff;
   logic                     in_range_ff;
   logic [SET_BITS-1:0]      addr_ff;
   logic [TAG_BITS-1:0]      tag_ff;
   logic [NEXT_USE_BITS-1:0] nu_ff;
   logic [TL_BITS-1:0]       tile_ff;
   logic                     in_range;
   logic [SET_BITS-1:0]      req_addr;

   // Clearing pass counter
   logic [SET_BITS-1:0]      clr_cnt_ff;
   logic [SET_BITS-1:0]      clr_cnt_in;

   // Memory ports
   logic [ST_WIDTH-1:0]      st_rd;
   logic [ST_WIDTH-1:0]      st_wr;
   logic [SET_BITS-1:0]      st_waddr;
   logic                     st_we;
   logic [TAG_WIDTH-1:0]     tag_rd;
   logic [TAG_WIDTH-1:0]     tag_wr;
   logic [TL_WIDTH-1:0]      tile_rd;
   logic [TL_WIDTH-1:0]      tile_wr;
   logic                     line_we;

   // Unpacked set row
   logic [NUM_WAYS-1:0]      row_valid;
   logic [NEXT_USE_BITS-1:0] row_nu   [NUM_WAYS];
   logic [TAG_BITS-1:0]      row_tag  [NUM_WAYS];
   logic [TL_BITS-1:0]       row_tile [NUM_WAYS];

   // Decision
   logic [NUM_WAYS-1:0]      hit_vec;
   logic                     hit_any;
   logic [WAY_BITS-1:0]      hit_way;
   logic                     free_any;
   logic [WAY_BITS-1:0]      free_way;
   logic [NEXT_USE_BITS-1:0] tree_nu  [LEVELS+1][PAD_WAYS];
   logic [WAY_BITS-1:0]      tree_way [LEVELS+1][PAD_WAYS];
   logic [WAY_BITS-1:0]      far_way;
   logic [WAY_BITS-1:0]      victim;
   logic [WAY_BITS-1:0]      way_sel;

   // Result register
   logic                              rsp_valid_ff;
   logic                              rsp_valid_in;
   logic                              rsp_hit_ff;
   logic [bor_pkg::WAY_OUT_BITS-1:0]  rsp_way_ff;
   logic                              rsp_evict_ff;
   logic [TL_BITS-1:0]                rsp_tile_ff;

   assign in_range = 32'(req_set_index) < 32'(SET_COUNT);
   assign req_addr = SET_BITS'(req_set_index);

   // Capture the request while its set rows are read
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cmd_ff      <= req_cmd;
         in_range_ff <= in_range;
         addr_ff     <= req_addr;
         tag_ff      <= TAG_BITS'(req_tag);
         nu_ff       <= NEXT_USE_BITS'(req_reuse_pos);
         tile_ff     <= req_tile;
      end
   end

   // Advance the clearing pass one row a cycle
   assign clr_cnt_in = cmd.clear_step ? clr_cnt_ff + SET_BITS'(1) : clr_cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else begin
         clr_cnt_ff <= clr_cnt_in;
      end
   end

   assign stat.clear_last = clr_cnt_ff == SET_BITS'(SET_COUNT - 1);
   assign stat.rsp_free   = !rsp_valid_ff || rsp_ready;

   // Split the rows into ways
   always_comb begin
      row_valid = st_rd[NUM_WAYS-1:0];
      for (int w = 0; w < NUM_WAYS; w++) begin
         row_nu[w]   = st_rd[NUM_WAYS + w * NEXT_USE_BITS +: NEXT_USE_BITS];
         row_tag[w]  = tag_rd[w * TAG_BITS +: TAG_BITS];
         row_tile[w] = tile_rd[w * TL_BITS +: TL_BITS];
         hit_vec[w]  = row_valid[w] && (row_tag[w] == tag_ff);
      end
   end

   // Find the lowest hit way and the lowest free way
   always_comb begin
      hit_any  = 1'b0;
      hit_way  = '0;
      free_any = 1'b0;
      free_way = '0;
      for (int w = NUM_WAYS - 1; w >= 0; w--) begin
         if (hit_vec[w]) begin
            hit_any = 1'b1;
            hit_way = WAY_BITS'(w);
         end
         if (!row_valid[w]) begin
            free_any = 1'b1;
            free_way = WAY_BITS'(w);
         end
      end
   end

   // Pick the farthest next use; the left side wins ties
   always_comb begin
      for (int i = 0; i < PAD_WAYS; i++) begin
         if (i < NUM_WAYS) begin
            tree_nu[0][i]  = row_nu[i];
         end else begin
            tree_nu[0][i]  = '0;
         end
         tree_way[0][i] = WAY_BITS'(i);
      end
      for (int l = 1; l <= LEVELS; l++) begin
         for (int i = 0; i < PAD_WAYS; i++) begin
            tree_nu[l][i]  = '0;
            tree_way[l][i] = '0;
         end
         for (int i = 0; i < (PAD_WAYS >> l); i++) begin
            if (tree_nu[l-1][2*i+1] > tree_nu[l-1][2*i]) begin
               tree_nu[l][i]  = tree_nu[l-1][2*i+1];
               tree_way[l][i] = tree_way[l-1][2*i+1];
            end else begin
               tree_nu[l][i]  = tree_nu[l-1][2*i];
               tree_way[l][i] = tree_way[l-1][2*i];
            end
         end
      end
      far_way = tree_way[LEVELS][0];
   end

   assign victim  = free_any ? free_way : far_way;
   assign way_sel = hit_any ? hit_way : victim;

   // Build the written-back rows
   always_comb begin
      st_wr   = st_rd;
      tag_wr  = tag_rd;
      tile_wr = tile_rd;
      for (int w = 0; w < NUM_WAYS; w++) begin
         if (WAY_BITS'(w) == way_sel) begin
            st_wr[NUM_WAYS + w * NEXT_USE_BITS +: NEXT_USE_BITS] = nu_ff;
         end
         if (!hit_any && WAY_BITS'(w) == victim) begin
            st_wr[w]                          = 1'b1;
            tag_wr[w * TAG_BITS +: TAG_BITS]  = tag_ff;
            tile_wr[w * TL_BITS +: TL_BITS]   = tile_ff;
         end
      end
      if (cmd.clear_step || cmd_ff == bor_pkg::CMD_FLUSH) begin
         st_wr = CLEAR_ROW;
      end
   end

   assign st_we    = cmd.clear_step || (cmd.resolve && in_range_ff);
   assign st_waddr = cmd.clear_step ? clr_cnt_ff : addr_ff;
   assign line_we  = cmd.resolve && in_range_ff && cmd_ff == bor_pkg::CMD_ACCESS && !hit_any;

   bor_ram #(
      .WIDTH (ST_WIDTH),
      .DEPTH (SET_COUNT)
   ) u_state_ram (
      .clock   (clock),
      .wr_en   (st_we),
      .wr_addr (st_waddr),
      .wr_data (st_wr),
      .rd_en   (cmd.capture),
      .rd_addr (req_addr),
      .rd_data (st_rd)
   );

   bor_ram #(
      .WIDTH (TAG_WIDTH),
      .DEPTH (SET_COUNT)
   ) u_tag_ram (
      .clock   (clock),
      .wr_en   (line_we),
      .wr_addr (addr_ff),
      .wr_data (tag_wr),
      .rd_en   (cmd.capture),
      .rd_addr (req_addr),
      .rd_data (tag_rd)
   );

   bor_ram #(
      .WIDTH (TL_WIDTH),
      .DEPTH (SET_COUNT)
   ) u_tile_ram (
      .clock   (clock),
      .wr_en   (line_we),
      .wr_addr (addr_ff),
      .wr_data (tile_wr),
      .rd_en   (cmd.capture),
      .rd_addr (req_addr),
      .rd_data (tile_rd)
   );

   // Load the result; drop valid once the transfer completes
   assign rsp_valid_in = cmd.resolve ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.resolve) begin
         rsp_hit_ff   <= 1'b0;
         rsp_way_ff   <= '0;
         rsp_evict_ff <= 1'b0;
         rsp_tile_ff  <= '0;
         if (in_range_ff && cmd_ff == bor_pkg::CMD_ACCESS) begin
            if (hit_any) begin
               rsp_hit_ff  <= 1'b1;
               rsp_way_ff  <= bor_pkg::WAY_OUT_BITS'(hit_way);
               rsp_tile_ff <= row_tile[hit_way];
            end else begin
               rsp_way_ff   <= bor_pkg::WAY_OUT_BITS'(victim);
               rsp_evict_ff <= !free_any;
            end
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_hit           = rsp_hit_ff;
   assign rsp_way_used      = rsp_way_ff;
   assign rsp_evicted_valid = rsp_evict_ff;
   assign rsp_hit_tile      = rsp_tile_ff;

endmodule

@@ rtl/belady_optimal_replacement_core.sv @@
// Set-associative tag store with farthest-next-use (Belady) replacement.
// req_chan carries one command per transfer: an access (set, tag, next-use
// position, tile id) that looks up the set and installs on a miss, or a
// flush that clears the named set. rsp_chan returns exactly one result per
// request: hit flag, way used, whether a valid line was evicted, and the
// stored tile id on a hit. Set indices of SET_COUNT and above are ignored
// and answer zero. For each request the set row is first read from the
// tag, tile and state memories as the request is taken; then all ways are
// compared, the way is picked and the row is written back. The result
// register is loaded with the write-back; a new request is taken while a
// result still waits to be transferred. If rsp_chan stalls with a result
// pending, the next request is read but held before write-back until the
// result register drains. Reset (synchronous) starts a clearing pass over
// all SET_COUNT sets that marks every line invalid with no future use;
// req_chan.ready stays low during it.
module belady_optimal_replacement_core #(
   parameter int SET_COUNT     = 64,
   parameter int NUM_WAYS      = 8,
   parameter int TAG_BITS      = 32,
   parameter int NEXT_USE_BITS = 32
) (
   input logic       clock,
   input logic       reset,
   bor_req_if.sink   req_chan,
   bor_rsp_if.source rsp_chan
);

   bor_pkg::ctl_cmd_type  ctl_cmd;
   bor_pkg::ctl_stat_type ctl_stat;

   bor_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .stat      (ctl_stat),
      .cmd       (ctl_cmd)
   );

   bor_datapath #(
      .SET_COUNT     (SET_COUNT),
      .NUM_WAYS      (NUM_WAYS),
      .TAG_BITS      (TAG_BITS),
      .NEXT_USE_BITS (NEXT_USE_BITS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (ctl_cmd),
      .stat              (ctl_stat),
      .req_cmd           (req_chan.cmd),
      .req_set_index     (req_chan.set_index),
      .req_tag           (req_chan.tag),
      .req_reuse_pos     (req_chan.reuse_pos),
      .req_tile          (req_chan.tile),
      .rsp_valid         (rsp_chan.valid),
      .rsp_ready         (rsp_chan.ready),
      .rsp_hit           (rsp_chan.hit),
      .rsp_way_used      (rsp_chan.way_used),
      .rsp_evicted_valid (rsp_chan.evicted_valid),
      .rsp_hit_tile      (rsp_chan.hit_tile)
   );

endmodule

@@ rtl/bor_checker.sv @@
module bor_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic                              rsp_hit,
   input logic [bor_pkg::WAY_OUT_BITS-1:0]  rsp_way_used,
   input logic                              rsp_evicted_valid,
   input logic [bor_pkg::TILE_BITS-1:0]     rsp_hit_tile
);

   // Reset starts the clearing pass, so no request is taken right after it
   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("request ready right after reset");

   // One request at a time: ready drops after each transfer
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second request taken while one is in flight");

   // A fresh result follows its request transfer: the request is captured, then resolved
   a_rsp_latency: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("result without a matching request");

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_hit)
         && $stable(rsp_way_used) && $stable(rsp_evicted_valid)
         && $stable(rsp_hit_tile)))
      else $error("stalled result changed");

endmodule

bind belady_optimal_replacement_core bor_checker u_bor_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_chan.valid),
   .req_ready         (req_chan.ready),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_hit           (rsp_chan.hit),
   .rsp_way_used      (rsp_chan.way_used),
   .rsp_evicted_valid (rsp_chan.evicted_valid),
   .rsp_hit_tile      (rsp_chan.hit_tile)
);

@@ test/tb_top.sv @@
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SET_COUNT    = 64;
   localparam int WAY_COUNT    = 8;
   localparam int LINE_COUNT   = SET_COUNT * WAY_COUNT;
   localparam int RANDOM_ITEMS = 1400;
   localparam int IDLE_PCT     = 21;
   localparam int HOLD_CYCLES  = 250;
   localparam int CYCLE_LIMIT  = 200000;
   localparam logic [bor_pkg::NEXT_USE_IN_BITS-1:0] NEVER_AGAIN = '1;

   typedef struct packed {
      logic                                 cmd;
      logic [bor_pkg::SET_IDX_BITS-1:0]     set_index;
      logic [bor_pkg::TAG_IN_BITS-1:0]      tag;
      logic [bor_pkg::NEXT_USE_IN_BITS-1:0] reuse_pos;
      logic [bor_pkg::TILE_BITS-1:0]        tile;
   } req_item_type;

   typedef struct packed {
      logic                             hit;
      logic [bor_pkg::WAY_OUT_BITS-1:0] way_used;
      logic                             evicted_valid;
      logic [bor_pkg::TILE_BITS-1:0]    hit_tile;
   } outcome_type;

   // Tag store copy and queue of outcomes still owed by the block
   class scoreboard_type;
      bit                                   line_valid [LINE_COUNT];
      logic [bor_pkg::TAG_IN_BITS-1:0]      line_tag [LINE_COUNT];
      logic [bor_pkg::NEXT_USE_IN_BITS-1:0] line_next_use [LINE_COUNT];
      logic [bor_pkg::TILE_BITS-1:0]        line_tile [LINE_COUNT];
      outcome_type                          expected_outcomes [$];
      int                                   failures;

      function new();
         for (int i = 0; i < LINE_COUNT; i++) begin
            line_valid[i]    = 1'b0;
            line_tag[i]      = '0;
            line_next_use[i] = NEVER_AGAIN;
            line_tile[i]     = '0;
         end
         failures = 0;
      endfunction

      function int pending();
         return expected_outcomes.size();
      endfunction

      // Apply one accepted request to the copy and queue its outcome
      function void note_request(req_item_type r);
         outcome_type                          o;
         int                                   base;
         int                                   hit_way;
         int                                   victim;
         bit                                   found;
         bit                                   full;
         logic [bor_pkg::NEXT_USE_IN_BITS-1:0] farthest;
         o = '0;
         base = int'(r.set_index) * WAY_COUNT;
         if (r.cmd == bor_pkg::CMD_FLUSH) begin
            for (int w = 0; w < WAY_COUNT; w++) begin
               line_valid[base + w]    = 1'b0;
               line_next_use[base + w] = NEVER_AGAIN;
            end
         end else begin
            found = 1'b0;
            hit_way = 0;
            for (int w = 0; w < WAY_COUNT; w++) begin
               if (!found && line_valid[base + w] && line_tag[base + w] == r.tag) begin
                  found = 1'b1;
                  hit_way = w;
               end
            end
            if (found) begin
               line_next_use[base + hit_way] = r.reuse_pos;
               o.hit = 1'b1;
               o.way_used = hit_way[bor_pkg::WAY_OUT_BITS-1:0];
               o.hit_tile = line_tile[base + hit_way];
            end else begin
               // lowest free way, else farthest next use with lowest way on ties
               full = 1'b1;
               victim = 0;
               for (int w = 0; w < WAY_COUNT; w++) begin
                  if (full && !line_valid[base + w]) begin
                     victim = w;
                     full = 1'b0;
                  end
               end
               if (full) begin
                  farthest = line_next_use[base];
                  for (int w = 1; w < WAY_COUNT; w++) begin
                     if (line_next_use[base + w] > farthest) begin
                        farthest = line_next_use[base + w];
                        victim = w;
                     end
                  end
               end
               line_valid[base + victim]    = 1'b1;
               line_tag[base + victim]      = r.tag;
               line_tile[base + victim]     = r.tile;
               line_next_use[base + victim] = r.reuse_pos;
               o.way_used = victim[bor_pkg::WAY_OUT_BITS-1:0];
               o.evicted_valid = full;
            end
         end
         expected_outcomes.push_back(o);
      endfunction

      // Compare one transferred result with the oldest owed outcome
      function void check_outcome(outcome_type got);
         outcome_type want;
         if (expected_outcomes.size() == 0) begin
            if (failures < 10)
               $display("unexpected result: hit=%0d way=%0d evicted=%0d tile=%h",
                        got.hit, got.way_used, got.evicted_valid, got.hit_tile);
            failures++;
         end else begin
            want = expected_outcomes.pop_front();
            if (got.hit !== want.hit || got.way_used !== want.way_used ||
                got.evicted_valid !== want.evicted_valid ||
                got.hit_tile !== want.hit_tile) begin
               if (failures < 10)
                  $display({"mismatch: expected hit=%0d way=%0d evicted=%0d tile=%h,",
                            " got hit=%0d way=%0d evicted=%0d tile=%h"},
                           want.hit, want.way_used, want.evicted_valid, want.hit_tile,
                           got.hit, got.way_used, got.evicted_valid, got.hit_tile);
               failures++;
            end
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   bor_req_if req_chan ();
   bor_rsp_if rsp_chan ();

   belady_optimal_replacement_core DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   scoreboard_type sb = new();

   bit steady = 1'b0;        // both sides run without idling
   int hold_requests = 0;    // bumped by the sender to ask for a long receiver stall
   int cycle_count = 0;
   logic [bor_pkg::TAG_IN_BITS-1:0] tag_pool [12];

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   function automatic req_item_type access_item(
         int                                   set_index,
         logic [bor_pkg::TAG_IN_BITS-1:0]      tag,
         logic [bor_pkg::NEXT_USE_IN_BITS-1:0] reuse_pos,
         logic [bor_pkg::TILE_BITS-1:0]        tile);
      req_item_type r;
      r.cmd = bor_pkg::CMD_ACCESS;
      r.set_index = set_index[bor_pkg::SET_IDX_BITS-1:0];
      r.tag = tag;
      r.reuse_pos = reuse_pos;
      r.tile = tile;
      return r;
   endfunction

   function automatic req_item_type flush_item(int set_index);
      req_item_type r;
      r = access_item(set_index, $urandom, $urandom, 16'($urandom_range(0, 65535)));
      r.cmd = bor_pkg::CMD_FLUSH;
      return r;
   endfunction

   // Mostly accesses to a few hot sets with pooled tags, so hits and evictions are common
   function automatic req_item_type random_item();
      req_item_type                         r;
      int                                   set_index;
      int                                   pick;
      logic [bor_pkg::TAG_IN_BITS-1:0]      tag;
      logic [bor_pkg::NEXT_USE_IN_BITS-1:0] reuse_pos;
      set_index = ($urandom_range(99) < 70) ? $urandom_range(0, 3) : $urandom_range(0, 63);
      tag = ($urandom_range(99) < 85) ? tag_pool[$urandom_range(0, 11)] : $urandom;
      pick = $urandom_range(99);
      if (pick < 40)
         reuse_pos = $urandom_range(0, 31);
      else if (pick < 55)
         reuse_pos = NEVER_AGAIN;
      else
         reuse_pos = $urandom;
      if ($urandom_range(99) < 3)
         r = flush_item(set_index);
      else
         r = access_item(set_index, tag, reuse_pos, 16'($urandom_range(0, 65535)));
      return r;
   endfunction

   // Offer one request, idling first at random, and return at its transfer
   task automatic offer(input req_item_type r);
      if (!steady) begin
         while ($urandom_range(99) < IDLE_PCT) begin
            req_chan.valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_chan.valid     <= 1'b1;
      req_chan.cmd       <= r.cmd;
      req_chan.set_index <= r.set_index;
      req_chan.tag       <= r.tag;
      req_chan.reuse_pos <= r.reuse_pos;
      req_chan.tile      <= r.tile;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      sb.note_request(r);
   endtask

   // Receiver: check transfers, then pick next ready
   initial begin
      int hold_left;
      int holds_seen;
      outcome_type got;
      hold_left = 0;
      holds_seen = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_chan.valid && rsp_chan.ready) begin
            got.hit = rsp_chan.hit;
            got.way_used = rsp_chan.way_used;
            got.evicted_valid = rsp_chan.evicted_valid;
            got.hit_tile = rsp_chan.hit_tile;
            sb.check_outcome(got);
         end
         if (reset) begin
            rsp_chan.ready <= 1'b0;
         end else if (hold_left > 0) begin
            rsp_chan.ready <= 1'b0;
            hold_left--;
         end else if (holds_seen != hold_requests) begin
            holds_seen = hold_requests;
            hold_left = HOLD_CYCLES;
            rsp_chan.ready <= 1'b0;
         end else if (steady) begin
            rsp_chan.ready <= 1'b1;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   // Watchdog
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      reset <= 1'b1;
      req_chan.valid     <= 1'b0;
      req_chan.cmd       <= bor_pkg::CMD_ACCESS;
      req_chan.set_index <= '0;
      req_chan.tag       <= '0;
      req_chan.reuse_pos <= '0;
      req_chan.tile      <= '0;
      for (int i = 0; i < 12; i++) tag_pool[i] = $urandom;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Fill set 0 through its free ways, tag and tile extremes included
      offer(access_item(0, 32'h0000_0000, 100, 16'h0000));
      offer(access_item(0, 32'hFFFF_FFFF, NEVER_AGAIN, 16'hFFFF));
      for (int k = 1; k <= 6; k++)
         offer(access_item(0, k, 10 * (k + 1), 16'(k)));
      // Hits update next use; then full-set misses evict the farthest
      offer(access_item(0, 32'h0000_0000, 5, 16'h1234));
      offer(access_item(0, 32'hFFFF_FFFF, 50, 16'h4321));
      offer(access_item(0, 7, 1, 16'hA5A5));
      offer(access_item(0, 8, 0, 16'h5A5A));
      // Tie on next use in set 63: lowest way goes
      for (int w = 0; w < 8; w++)
         offer(access_item(63, 32'h8000_0000 + w, NEVER_AGAIN, 16'(16'h8000 + w)));
      offer(access_item(63, 32'h8000_0100, 3, 16'h00FF));
      // Flush, then a former tag misses into a free way
      offer(flush_item(63));
      offer(access_item(63, 32'h8000_0003, 9, 16'h0F0F));
      offer(flush_item(0));

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == 300) hold_requests++;
         if (n == 500) steady = 1'b1;
         if (n == 800) steady = 1'b0;
         if (n == 1000) begin
            req_chan.valid <= 1'b0;
            @(posedge clock);
            while (sb.pending() != 0) @(posedge clock);
         end
         offer(random_item());
      end
      req_chan.valid <= 1'b0;

      // Drain, then allow a few more cycles for anything stray
      while (sb.pending() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (sb.failures == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

@@ sim.f @@
rtl/bor_pkg.sv
rtl/bor_req_if.sv
rtl/bor_rsp_if.sv
rtl/bor_ram.sv
rtl/bor_ctrl.sv
rtl/bor_datapath.sv
rtl/belady_optimal_replacement_core.sv
rtl/bor_checker.sv
test/tb_top.sv
